FILE: sv/tphi_pkg.sv
// ----------------------------------------------------------------------------
// tphi_pkg
// Shared constants and control types for the triangle plane height
// interpolator pipeline.
// ----------------------------------------------------------------------------
package tphi_pkg;

    localparam int COORD_BITS_DEF = 24;

    typedef struct packed {
        logic vld;
        logic neg;
        logic deg;
        logic ovf;
    } tphi_ctl_t;

endpackage

FILE: sv/triangle_plane_height_interpolator.sv
// ----------------------------------------------------------------------------
// triangle_plane_height_interpolator
// Plane height of a triangle at a query point, by Cramer's rule with a
// rounded exact quotient, saturated to the coordinate range.
// ----------------------------------------------------------------------------
// Fully pipelined: one beat accepted per cycle unless the output stalls;
// six front stages, one restoring divider stage per quotient bit, two
// finishing stages. The whole pipeline stalls together while a result
// beat waits at the output. Coordinates are two's complement fixed point;
// the fraction position does not affect the result. A zero determinant
// returns vertex a's height with degenerate set.
// ----------------------------------------------------------------------------
module triangle_plane_height_interpolator #(
    parameter int COORD_BITS = tphi_pkg::COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_BITS-1:0]  s_a_x,
    input  logic signed [COORD_BITS-1:0]  s_a_y,
    input  logic signed [COORD_BITS-1:0]  s_a_z,
    input  logic signed [COORD_BITS-1:0]  s_b_x,
    input  logic signed [COORD_BITS-1:0]  s_b_y,
    input  logic signed [COORD_BITS-1:0]  s_b_z,
    input  logic signed [COORD_BITS-1:0]  s_c_x,
    input  logic signed [COORD_BITS-1:0]  s_c_y,
    input  logic signed [COORD_BITS-1:0]  s_c_z,
    input  logic signed [COORD_BITS-1:0]  s_query_x,
    input  logic signed [COORD_BITS-1:0]  s_query_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_BITS-1:0]  m_height,
    output logic                          m_degenerate,
    output logic                          m_saturated
);
    localparam int PW = 2 * COORD_BITS + 3;
    localparam int QB = COORD_BITS + 1;

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    tphi_pkg::tphi_ctl_t          ctl_w  [QB+1];
    logic signed [COORD_BITS-1:0] az_w   [QB+1];
    logic [PW-1:0]                dabs_w [QB+1];
    logic [PW-1:0]                rem_w  [QB+1];
    logic [QB-1:0]                nlow_w [QB+1];
    logic [QB-1:0]                q_w    [QB+1];

    assign q_w[0] = '0;

    tphi_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .en(en), .in_vld(s_valid && s_ready),
        .a_x(s_a_x), .a_y(s_a_y), .a_z(s_a_z),
        .b_x(s_b_x), .b_y(s_b_y), .b_z(s_b_z),
        .c_x(s_c_x), .c_y(s_c_y), .c_z(s_c_z),
        .query_x(s_query_x), .query_y(s_query_y),
        .ctl_o(ctl_w[0]), .az_o(az_w[0]), .dabs_o(dabs_w[0]),
        .rem_o(rem_w[0]), .nlow_o(nlow_w[0])
    );

    for (genvar i = 0; i < QB; i++) begin : g_div
        tphi_div_stage #(.COORD_BITS(COORD_BITS)) u_stage (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .ctl_i(ctl_w[i]), .az_i(az_w[i]), .dabs_i(dabs_w[i]),
            .rem_i(rem_w[i]), .nlow_i(nlow_w[i]), .q_i(q_w[i]),
            .ctl_o(ctl_w[i+1]), .az_o(az_w[i+1]), .dabs_o(dabs_w[i+1]),
            .rem_o(rem_w[i+1]), .nlow_o(nlow_w[i+1]), .q_o(q_w[i+1])
        );
    end

    tphi_finish #(.COORD_BITS(COORD_BITS)) u_finish (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .ctl_i(ctl_w[QB]), .az_i(az_w[QB]), .dabs_i(dabs_w[QB]),
        .rem_i(rem_w[QB]), .q_i(q_w[QB]),
        .out_vld(m_valid), .height(m_height),
        .degenerate(m_degenerate), .saturated(m_saturated)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> !m_saturated)
        else $error("degenerate beat flagged saturated");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |->
            (m_height == {1'b0, {(COORD_BITS-1){1'b1}}}) ||
            (m_height == {1'b1, {(COORD_BITS-1){1'b0}}}))
        else $error("saturated beat not at a range limit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("stalled result beat dropped");

endmodule

FILE: sv/tphi_front.sv
// ----------------------------------------------------------------------------
// tphi_front
// Edge vectors, Cramer products, numerator assembly, magnitudes and
// quotient range check (six register stages).
// ----------------------------------------------------------------------------
module tphi_front #(
    parameter int COORD_BITS = tphi_pkg::COORD_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_vld,
    input  logic signed [COORD_BITS-1:0]       a_x,
    input  logic signed [COORD_BITS-1:0]       a_y,
    input  logic signed [COORD_BITS-1:0]       a_z,
    input  logic signed [COORD_BITS-1:0]       b_x,
    input  logic signed [COORD_BITS-1:0]       b_y,
    input  logic signed [COORD_BITS-1:0]       b_z,
    input  logic signed [COORD_BITS-1:0]       c_x,
    input  logic signed [COORD_BITS-1:0]       c_y,
    input  logic signed [COORD_BITS-1:0]       c_z,
    input  logic signed [COORD_BITS-1:0]       query_x,
    input  logic signed [COORD_BITS-1:0]       query_y,
    output tphi_pkg::tphi_ctl_t                ctl_o,
    output logic signed [COORD_BITS-1:0]       az_o,
    output logic [2*COORD_BITS+2:0]            dabs_o,
    output logic [2*COORD_BITS+2:0]            rem_o,
    output logic [COORD_BITS:0]                nlow_o
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS + 3;
    localparam int NW = 3 * COORD_BITS + 5;
    localparam int LW = COORD_BITS + 1;
    localparam int QB = COORD_BITS + 1;

    // stage 1
    logic                 v1_reg;
    logic signed [DW-1:0] d1x_reg, d1y_reg, d1z_reg, d2x_reg, d2y_reg, d2z_reg;
    logic signed [DW-1:0] px_reg, py_reg;
    logic signed [COORD_BITS-1:0] az1_reg;
    // stage 2
    logic                 v2_reg;
    logic signed [PW-1:0] det2_reg, n1_reg, n2_reg;
    logic signed [DW-1:0] e1z_reg, e2z_reg;
    logic signed [COORD_BITS-1:0] az2_reg;
    // stage 3
    logic                 v3_reg, deg3_reg;
    logic signed [PW-1:0] pl1_reg, ph1_reg, pl2_reg, ph2_reg, det3_reg;
    logic signed [COORD_BITS-1:0] az3_reg;
    // stage 4
    logic                 v4_reg, deg4_reg;
    logic signed [NW-1:0] num_reg;
    logic signed [PW-1:0] det4_reg;
    logic signed [COORD_BITS-1:0] az4_reg;
    // stage 5
    logic                 v5_reg, deg5_reg, neg5_reg;
    logic [NW-1:0]        nabs_reg;
    logic [PW-1:0]        dabs5_reg;
    logic signed [COORD_BITS-1:0] az5_reg;
    // stage 6
    tphi_pkg::tphi_ctl_t  ctl6_reg;
    logic [PW-1:0]        dabs6_reg, rem6_reg;
    logic [QB-1:0]        nlow6_reg;
    logic signed [COORD_BITS-1:0] az6_reg;

    logic signed [PW-1:0] det_next, n1_next, n2_next;
    logic signed [NW-1:0] num_next;
    logic [NW-1:0]        nabs_next, nhigh;

    assign det_next = PW'(d1x_reg * d2y_reg) - PW'(d2x_reg * d1y_reg);
    assign n1_next  = PW'(px_reg * d2y_reg) - PW'(py_reg * d2x_reg);
    assign n2_next  = PW'(d1x_reg * py_reg) - PW'(d1y_reg * px_reg);
    assign num_next = (NW'(ph1_reg) << LW) + NW'(pl1_reg)
                    + (NW'(ph2_reg) << LW) + NW'(pl2_reg);
    assign nabs_next = num_reg[NW-1] ? NW'(-num_reg) : NW'(num_reg);
    assign nhigh     = nabs_reg >> QB;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            ctl6_reg <= '0;
        end else if (en) begin
            v1_reg       <= in_vld;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            v5_reg       <= v4_reg;
            ctl6_reg.vld <= v5_reg;
            ctl6_reg.neg <= neg5_reg;
            ctl6_reg.deg <= deg5_reg;
            ctl6_reg.ovf <= nhigh >= NW'(dabs5_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d1x_reg <= DW'(b_x) - DW'(a_x);
            d1y_reg <= DW'(b_y) - DW'(a_y);
            d1z_reg <= DW'(b_z) - DW'(a_z);
            d2x_reg <= DW'(c_x) - DW'(a_x);
            d2y_reg <= DW'(c_y) - DW'(a_y);
            d2z_reg <= DW'(c_z) - DW'(a_z);
            px_reg  <= DW'(query_x) - DW'(a_x);
            py_reg  <= DW'(query_y) - DW'(a_y);
            az1_reg <= a_z;

            det2_reg <= det_next;
            n1_reg   <= n1_next;
            n2_reg   <= n2_next;
            e1z_reg  <= d1z_reg;
            e2z_reg  <= d2z_reg;
            az2_reg  <= az1_reg;

            pl1_reg  <= PW'($signed({1'b0, n1_reg[LW-1:0]}) * e1z_reg);
            ph1_reg  <= PW'($signed(n1_reg[PW-1:LW]) * e1z_reg);
            pl2_reg  <= PW'($signed({1'b0, n2_reg[LW-1:0]}) * e2z_reg);
            ph2_reg  <= PW'($signed(n2_reg[PW-1:LW]) * e2z_reg);
            det3_reg <= det2_reg;
            deg3_reg <= det2_reg == '0;
            az3_reg  <= az2_reg;

            num_reg  <= num_next;
            det4_reg <= det3_reg;
            deg4_reg <= deg3_reg;
            az4_reg  <= az3_reg;

            nabs_reg  <= nabs_next;
            dabs5_reg <= det4_reg[PW-1] ? PW'(-det4_reg) : PW'(det4_reg);
            neg5_reg  <= num_reg[NW-1] ^ det4_reg[PW-1];
            deg5_reg  <= deg4_reg;
            az5_reg   <= az4_reg;

            dabs6_reg <= dabs5_reg;
            rem6_reg  <= PW'(nhigh);
            nlow6_reg <= nabs_reg[QB-1:0];
            az6_reg   <= az5_reg;
        end
    end

    assign ctl_o  = ctl6_reg;
    assign az_o   = az6_reg;
    assign dabs_o = dabs6_reg;
    assign rem_o  = rem6_reg;
    assign nlow_o = nlow6_reg;

endmodule

FILE: sv/tphi_div_stage.sv
// ----------------------------------------------------------------------------
// tphi_div_stage
// One restoring division step: shift in a numerator bit, trial subtract,
// shift in one quotient bit.
// ----------------------------------------------------------------------------
module tphi_div_stage #(
    parameter int COORD_BITS = tphi_pkg::COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  tphi_pkg::tphi_ctl_t           ctl_i,
    input  logic signed [COORD_BITS-1:0]  az_i,
    input  logic [2*COORD_BITS+2:0]       dabs_i,
    input  logic [2*COORD_BITS+2:0]       rem_i,
    input  logic [COORD_BITS:0]           nlow_i,
    input  logic [COORD_BITS:0]           q_i,
    output tphi_pkg::tphi_ctl_t           ctl_o,
    output logic signed [COORD_BITS-1:0]  az_o,
    output logic [2*COORD_BITS+2:0]       dabs_o,
    output logic [2*COORD_BITS+2:0]       rem_o,
    output logic [COORD_BITS:0]           nlow_o,
    output logic [COORD_BITS:0]           q_o
);
    localparam int PW = 2 * COORD_BITS + 3;
    localparam int QB = COORD_BITS + 1;

    tphi_pkg::tphi_ctl_t          ctl_reg;
    logic signed [COORD_BITS-1:0] az_reg;
    logic [PW-1:0]                dabs_reg, rem_reg;
    logic [QB-1:0]                nlow_reg, q_reg;

    logic [PW:0] trial;
    logic        take;

    assign trial = {rem_i, nlow_i[QB-1]};
    assign take  = trial >= {1'b0, dabs_i};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            az_reg   <= az_i;
            dabs_reg <= dabs_i;
            rem_reg  <= take ? PW'(trial - {1'b0, dabs_i}) : PW'(trial);
            nlow_reg <= nlow_i << 1;
            q_reg    <= {q_i[QB-2:0], take};
        end
    end

    assign ctl_o  = ctl_reg;
    assign az_o   = az_reg;
    assign dabs_o = dabs_reg;
    assign rem_o  = rem_reg;
    assign nlow_o = nlow_reg;
    assign q_o    = q_reg;

endmodule

FILE: sv/tphi_finish.sv
// ----------------------------------------------------------------------------
// tphi_finish
// Rounds and signs the quotient, adds the base height, clamps, and holds
// the result beat (two register stages).
// ----------------------------------------------------------------------------
module tphi_finish #(
    parameter int COORD_BITS = tphi_pkg::COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  tphi_pkg::tphi_ctl_t           ctl_i,
    input  logic signed [COORD_BITS-1:0]  az_i,
    input  logic [2*COORD_BITS+2:0]       dabs_i,
    input  logic [2*COORD_BITS+2:0]       rem_i,
    input  logic [COORD_BITS:0]           q_i,
    output logic                          out_vld,
    output logic signed [COORD_BITS-1:0]  height,
    output logic                          degenerate,
    output logic                          saturated
);
    localparam int PW = 2 * COORD_BITS + 3;
    localparam int QB = COORD_BITS + 1;
    localparam int SW = QB + 3;

    tphi_pkg::tphi_ctl_t          ctl_reg;
    logic signed [QB+1:0]         sq_reg;
    logic signed [COORD_BITS-1:0] az_reg;
    logic                         vld_reg, deg_reg, sat_reg;
    logic signed [COORD_BITS-1:0] h_reg;

    logic [QB:0]          qr;
    logic signed [SW-1:0] hsum, hmax, hmin;
    logic signed [COORD_BITS-1:0] h_next;
    logic                 sat_next;

    assign qr   = {1'b0, q_i} + QB'({rem_i, 1'b0} >= {1'b0, dabs_i});
    assign hsum = SW'(az_reg) + SW'(sq_reg);
    assign hmax = SW'({1'b0, {(COORD_BITS-1){1'b1}}});
    assign hmin = -hmax - SW'(1);

    always_comb begin
        h_next   = COORD_BITS'(hsum);
        sat_next = 1'b0;
        priority if (ctl_reg.deg) begin
            h_next = az_reg;
        end else if (ctl_reg.ovf) begin
            h_next   = ctl_reg.neg ? COORD_BITS'(hmin) : COORD_BITS'(hmax);
            sat_next = 1'b1;
        end else if (hsum > hmax) begin
            h_next   = COORD_BITS'(hmax);
            sat_next = 1'b1;
        end else if (hsum < hmin) begin
            h_next   = COORD_BITS'(hmin);
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
            vld_reg <= 1'b0;
        end else if (en) begin
            ctl_reg <= ctl_i;
            vld_reg <= ctl_reg.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg  <= ctl_i.neg ? -$signed({1'b0, qr}) : $signed({1'b0, qr});
            az_reg  <= az_i;
            h_reg   <= h_next;
            deg_reg <= ctl_reg.deg;
            sat_reg <= sat_next;
        end
    end

    assign out_vld    = vld_reg;
    assign height     = h_reg;
    assign degenerate = deg_reg;
    assign saturated  = sat_reg;

endmodule
